// File: hdl/pfs_pkg.sv
// Package for the page frame free stack: sizes, status codes, register
// indexes and the control state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;
    localparam int MAX_PAGES     = 4096;
    localparam int PTR_BITS      = $clog2(MAX_PAGES);
    localparam int COUNT_BITS    = $clog2(MAX_PAGES + 1);
    localparam int PFN_BITS      = ADDR_BITS - PAGE_SHIFT;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_IDX_LSB   = 3;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_MISALIGNED = 3'd1,
        STATUS_KERNEL     = 3'd2,
        STATUS_BOOTINFO   = 3'd3,
        STATUS_MODULE     = 3'd4,
        STATUS_FULL       = 3'd5,
        STATUS_EMPTY      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        REG_KERNEL_LO     = 3'd0,
        REG_KERNEL_HI     = 3'd1,
        REG_BOOTINFO_BASE = 3'd2,
        REG_BOOTINFO_LEN  = 3'd3,
        REG_MODULE_LO     = 3'd4,
        REG_MODULE_HI     = 3'd5
    } reg_idx_t;

    typedef enum logic {
        MODE_FREE  = 1'b0,
        MODE_ALLOC = 1'b1
    } mode_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

endpackage

`default_nettype wire

// File: hdl/pfs_req_if.sv
// Request channel of the page frame free stack: valid, ready and payload.
// Depends on pfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfs_req_if
    import pfs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [ADDR_BITS-1:0] page_addr;

    modport source (output valid, output mode, output page_addr, input ready);
    modport sink (input valid, input mode, input page_addr, output ready);
endinterface

`default_nettype wire

// File: hdl/pfs_rsp_if.sv
// Response channel of the page frame free stack: valid, ready and payload.
// Depends on pfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfs_rsp_if
    import pfs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ADDR_BITS-1:0]  granted_addr;
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] pages_free;

    modport source (output valid, output granted_addr, output status, output pages_free,
                    input ready);
    modport sink (input valid, input granted_addr, input status, input pages_free,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/page_frame_free_stack.sv
// Page frame free stack: top level with the page store memory, the request
// sequencer and the register port. Depends on pfs_pkg, pfs_req_if, pfs_rsp_if.
//
// Usage: a request on req frees the page at page_addr (mode 0) or allocates
// one page (mode 1). Each request gives exactly one transfer on rsp with the
// granted address, a status code and the number of free pages afterwards.
// A free is refused when the address is misaligned or lies in the kernel
// image, the boot information block or the module region, and when the
// store already holds every page; an allocate on an empty store reports it.
// Free pages live in a stack memory with one read port, one write port and
// registered read data. A request is taken in the idle state and executed in
// the execute state, when the memory read of the top entry is back; the block
// takes no new request until the last one has executed. The result is held
// in an output register; while the receiver stalls, the block accepts one
// more request and then waits in its execute state until the register frees.
// Reset empties the stack and clears all protection registers to zero; no
// clearing pass runs, the block takes requests right after reset.
// Registers sit at byte addresses 8*i on the APB port, 64-bit data.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_free_stack
    import pfs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    pfs_req_if.sink                       req,
    pfs_rsp_if.source                     rsp,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [ADDR_BITS-1:0]  kernel_lo_reg;
    logic [ADDR_BITS-1:0]  kernel_hi_reg;
    logic [ADDR_BITS-1:0]  bootinfo_base_reg;
    logic [ADDR_BITS-1:0]  bootinfo_len_reg;
    logic [ADDR_BITS-1:0]  module_lo_reg;
    logic [ADDR_BITS-1:0]  module_hi_reg;

    logic [ADDR_BITS:0]    boot_end_reg;
    logic [ADDR_BITS:0]    mod_start_reg;
    logic [ADDR_BITS:0]    mod_end_reg;
    logic                  mod_on_reg;
    logic [ADDR_BITS:0]    mod_sum;

    fsm_t                  state_reg;
    fsm_t                  state_next;
    logic [COUNT_BITS-1:0] top_reg;
    logic [COUNT_BITS-1:0] top_next;
    logic                  mode_reg;
    logic [ADDR_BITS-1:0]  addr_reg;

    logic [PFN_BITS-1:0]   store [MAX_PAGES];
    logic [PFN_BITS-1:0]   rd_data_reg;
    logic                  rd_en;
    logic [PTR_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] top_dec;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ADDR_BITS-1:0]  granted_reg;
    logic [ADDR_BITS-1:0]  granted_next;
    status_t               status_reg;
    status_t               status_next;
    logic [COUNT_BITS-1:0] free_reg;
    logic                  fire;
    logic                  accept;

    logic                  cfg_wr;
    reg_idx_t              cfg_idx;
    logic [ADDR_BITS:0]    addr_ext;
    status_t               free_status;

    // Register port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[CFG_IDX_LSB +: 3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_lo_reg     <= '0;
            kernel_hi_reg     <= '0;
            bootinfo_base_reg <= '0;
            bootinfo_len_reg  <= '0;
            module_lo_reg     <= '0;
            module_hi_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_KERNEL_LO:     kernel_lo_reg     <= pwdata[ADDR_BITS-1:0];
                REG_KERNEL_HI:     kernel_hi_reg     <= pwdata[ADDR_BITS-1:0];
                REG_BOOTINFO_BASE: bootinfo_base_reg <= pwdata[ADDR_BITS-1:0];
                REG_BOOTINFO_LEN:  bootinfo_len_reg  <= pwdata[ADDR_BITS-1:0];
                REG_MODULE_LO:     module_lo_reg     <= pwdata[ADDR_BITS-1:0];
                REG_MODULE_HI:     module_hi_reg     <= pwdata[ADDR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_KERNEL_LO:     prdata = CFG_DATA_BITS'(kernel_lo_reg);
            REG_KERNEL_HI:     prdata = CFG_DATA_BITS'(kernel_hi_reg);
            REG_BOOTINFO_BASE: prdata = CFG_DATA_BITS'(bootinfo_base_reg);
            REG_BOOTINFO_LEN:  prdata = CFG_DATA_BITS'(bootinfo_len_reg);
            REG_MODULE_LO:     prdata = CFG_DATA_BITS'(module_lo_reg);
            REG_MODULE_HI:     prdata = CFG_DATA_BITS'(module_hi_reg);
            default:           prdata = '0;
        endcase
    end

    // Region bounds derived from the registers and registered.
    assign mod_sum = {1'b0, module_hi_reg} + (ADDR_BITS + 1)'(PAGE_BYTES - 1);

    always_ff @(posedge clk)
    begin
        boot_end_reg  <= {1'b0, bootinfo_base_reg} + {1'b0, bootinfo_len_reg};
        mod_start_reg <= {1'b0, module_lo_reg[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        mod_end_reg   <= {mod_sum[ADDR_BITS:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        mod_on_reg    <= (module_lo_reg != '0);
    end

    // Request capture.
    assign req.ready = (state_reg == FSM_IDLE);
    assign accept    = req.valid && req.ready;
    assign top_dec   = top_reg - COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            addr_reg <= req.page_addr;
        end
    end

    // Page store: one read port, one write port, registered read data.
    assign rd_en   = accept && (req.mode == MODE_ALLOC);
    assign rd_addr = top_dec[PTR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[top_reg[PTR_BITS-1:0]] <= addr_reg[ADDR_BITS-1:PAGE_SHIFT];
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    // Free checks in priority order.
    assign addr_ext = {1'b0, addr_reg};

    always_comb
    begin
        if (addr_reg[PAGE_SHIFT-1:0] != '0)
        begin
            free_status = STATUS_MISALIGNED;
        end
        else if (addr_reg >= kernel_lo_reg && addr_reg < kernel_hi_reg)
        begin
            free_status = STATUS_KERNEL;
        end
        else if (addr_reg >= bootinfo_base_reg && addr_ext < boot_end_reg)
        begin
            free_status = STATUS_BOOTINFO;
        end
        else if (mod_on_reg && addr_ext >= mod_start_reg && addr_ext < mod_end_reg)
        begin
            free_status = STATUS_MODULE;
        end
        else if (top_reg >= COUNT_BITS'(MAX_PAGES))
        begin
            free_status = STATUS_FULL;
        end
        else
        begin
            free_status = STATUS_OK;
        end
    end

    // Execute step and sequencer.
    assign fire = (state_reg == FSM_EXEC) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        wr_en          = 1'b0;
        granted_next   = '0;
        status_next    = STATUS_OK;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (fire)
                begin
                    state_next     = FSM_IDLE;
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            top_next     = top_dec;
                            granted_next = {rd_data_reg, {PAGE_SHIFT{1'b0}}};
                        end
                    end
                    else
                    begin
                        status_next = free_status;
                        if (free_status == STATUS_OK)
                        begin
                            wr_en    = 1'b1;
                            top_next = top_reg + COUNT_BITS'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            free_reg    <= top_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_addr = granted_reg;
    assign rsp.status       = status_reg;
    assign rsp.pages_free   = free_reg;

    // The stack never holds more pages than the store has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= COUNT_BITS'(MAX_PAGES))
        else $error("page count exceeds store depth");

    // A request is never taken while another one is executing.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken during execute");

    // The page count changes only when a result is issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg != $past(top_reg) |-> $past(fire))
        else $error("page count changed without a result");

    // A refused or empty request never grants an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STATUS_OK |-> rsp.granted_addr == '0)
        else $error("address granted with error status");

    // A pending result stays valid with a stable page count while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(free_reg))
        else $error("pending result lost");

endmodule

`default_nettype wire
